// File: rtl/core/memory_value_scan_filter_unit_assert.svh
// Assertion macros used by the checker of the scan filter unit.
`ifndef MEMORY_VALUE_SCAN_FILTER_UNIT_ASSERT_SVH
`define MEMORY_VALUE_SCAN_FILTER_UNIT_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define MVSF_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("scan filter check failed");

// Check that post holds in the cycle after pre.
`define MVSF_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("scan filter check failed");

`endif

// File: rtl/core/mvsf_pkg.sv
// Types, constants and helper functions of the memory value scan filter.
package mvsf_pkg;

  localparam int SLOT_W      = 12;
  localparam int SLOT_COUNT  = 1 << SLOT_W;
  localparam int COUNT_W     = SLOT_W + 1;
  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = OPTR_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE  = 2'd2;

  // Element width codes; any other code means four bytes.
  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  typedef enum logic [1:0] {
    MODE_ANY = 2'd0,
    MODE_EQ  = 2'd1,
    MODE_INC = 2'd2,
    MODE_DEC = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] sample;
    logic              first_of_pass;
  } scan_item_t;

  typedef struct packed {
    logic               still_candidate;
    logic [COUNT_W-1:0] candidates_so_far;
    logic               pass_skipped;
  } scan_result_t;

  typedef struct packed {
    scan_mode_t        scan_mode;
    logic [1:0]        element_width;
    logic [DATA_W-1:0] target_value;
  } cfg_t;

  // Item as classified by the front end.
  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] now_value;
    logic              first_of_pass;
    logic              eq_hit;
  } work_t;

  function automatic logic [DATA_W-1:0] cut_to_width(input logic [1:0] width,
                                                    input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] r;
    begin
      r = value;
      if (width == WIDTH_BYTE) begin
        r = {{(DATA_W-8){1'b0}}, value[7:0]};
      end else if (width == WIDTH_HALF) begin
        r = {{(DATA_W-16){1'b0}}, value[15:0]};
      end
      return r;
    end
  endfunction

endpackage

// File: rtl/core/memory_value_scan_filter_unit.sv
// Top level of the memory value scan filter unit.
//
// Each item names one memory slot, carries the freshly read sample and marks
// the first slot of a scan pass; each item yields exactly one result telling
// whether the slot is still a candidate, how many slots have passed so far in
// this pass and whether the pass is skipped (no candidates were left when it
// started). Throughput is one item per clock unless full stalls it: the back end does a
// read-modify-write of the slot's candidate bit and previous sample in two
// stages, and a repeated slot on consecutive items is served by forwarding the
// write instead of waiting on the memory. An accepted item passes through the
// front register, the queue, the memory read and execute stage and the result
// queue before its result shows on the result ports. After reset the unit sweeps
// the 4096-entry candidate mask back to all ones, one slot per cycle, and holds
// full high until the sweep is done; configuration writes are taken at any time
// and should only be made while no item is in flight.
module memory_value_scan_filter_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  mvsf_pkg::scan_item_t                  scan_item,
  output logic                                  empty,
  input  logic                                  pop,
  output mvsf_pkg::scan_result_t                scan_result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mvsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvsf_pkg::DATA_W-1:0]           cfg_data
);

  mvsf_pkg::cfg_t   cfg;
  logic             busy;
  logic             front_valid;
  logic             front_ready;
  mvsf_pkg::work_t  front_work;
  logic             queue_valid;
  logic             queue_ready;
  mvsf_pkg::work_t  queue_work;

  // Configuration registers: always ready, a write to an unused index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_mode     <= mvsf_pkg::MODE_ANY;
      cfg.element_width <= mvsf_pkg::WIDTH_WORD;
      cfg.target_value  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mvsf_pkg::CFG_SCAN_MODE:     cfg.scan_mode     <= mvsf_pkg::scan_mode_t'(cfg_data[1:0]);
        mvsf_pkg::CFG_ELEMENT_WIDTH: cfg.element_width <= cfg_data[1:0];
        mvsf_pkg::CFG_TARGET_VALUE:  cfg.target_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: accept the item, truncate the sample, match it against the target.
  mvsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .scan_item (scan_item),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_work  (front_work)
  );

  // Decouple the front end from stalls of the back end.
  mvsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_work   (front_work),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_work  (queue_work)
  );

  // Back end: update slot state and pass count, queue the results.
  mvsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .work_valid  (queue_valid),
    .work_ready  (queue_ready),
    .work        (queue_work),
    .busy        (busy),
    .empty       (empty),
    .pop         (pop),
    .scan_result (scan_result)
  );

endmodule

// File: rtl/core/mvsf_front.sv
// Front end: accept items, truncate the sample and precompute the target match.
module mvsf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mvsf_pkg::scan_item_t scan_item,
  input  mvsf_pkg::cfg_t      cfg,
  input  logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output mvsf_pkg::work_t     out_work
);

  logic               hold_valid;
  mvsf_pkg::work_t    hold;
  mvsf_pkg::work_t    classified;
  logic               accept;

  always_comb begin
    classified.slot_index    = scan_item.slot_index;
    classified.sample        = scan_item.sample;
    classified.first_of_pass = scan_item.first_of_pass;
    classified.now_value     = mvsf_pkg::cut_to_width(cfg.element_width, scan_item.sample);
    classified.eq_hit        = (classified.now_value == cfg.target_value);
  end

  // Unless busy, take a new item when the holding stage is empty or drains this cycle.
  assign full   = busy || (hold_valid && !out_ready);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (out_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= classified;
    end
  end

  assign out_valid = hold_valid;
  assign out_work  = hold;

endmodule

// File: rtl/core/mvsf_queue.sv
// Short register queue of classified items between front end and back end.
module mvsf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mvsf_pkg::work_t in_work,
  output logic            out_valid,
  input  logic            out_ready,
  output mvsf_pkg::work_t out_work
);

  mvsf_pkg::work_t                  slots [mvsf_pkg::QUEUE_DEPTH];
  logic [mvsf_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mvsf_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mvsf_pkg::QCNT_W-1:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign in_ready  = (count != mvsf_pkg::QCNT_W'(mvsf_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;
  assign out_work  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + mvsf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + mvsf_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + mvsf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - mvsf_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_work;
    end
  end

endmodule

// File: rtl/core/mvsf_back.sv
// Back end: slot memories, read-modify-write filter step, pass count, result queue.
module mvsf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mvsf_pkg::cfg_t        cfg,
  input  logic                  work_valid,
  output logic                  work_ready,
  input  mvsf_pkg::work_t       work,
  output logic                  busy,
  output logic                  empty,
  input  logic                  pop,
  output mvsf_pkg::scan_result_t scan_result
);

  // Clearing sweep of the candidate mask after reset.
  logic                               clearing;
  logic [mvsf_pkg::SLOT_W-1:0]        clear_idx;

  // Slot memories.
  logic                               mask_mem [mvsf_pkg::SLOT_COUNT];
  logic [mvsf_pkg::DATA_W-1:0]        prev_mem [mvsf_pkg::SLOT_COUNT];
  logic                               mask_rd;
  logic [mvsf_pkg::DATA_W-1:0]        prev_rd;

  // Forwarding of a write to the slot read in the same cycle.
  logic                               byp_hit;
  logic                               byp_mask;
  logic [mvsf_pkg::DATA_W-1:0]        byp_prev;

  // Execute stage.
  logic                               s1_valid;
  mvsf_pkg::work_t                    s1;
  logic                               pass_live;
  logic [mvsf_pkg::COUNT_W-1:0]       count;

  logic                               issue;
  logic [mvsf_pkg::OCNT_W-1:0]        in_flight;
  logic                               cur_mask;
  logic [mvsf_pkg::DATA_W-1:0]        prev_cut;
  logic                               live_next;
  logic [mvsf_pkg::COUNT_W-1:0]       base;
  logic                               ok;
  logic                               bit_next;
  logic [mvsf_pkg::COUNT_W-1:0]       count_next;
  logic                               we;
  mvsf_pkg::scan_result_t             result;

  // Result queue.
  mvsf_pkg::scan_result_t             out_mem [mvsf_pkg::OUT_DEPTH];
  logic [mvsf_pkg::OPTR_W-1:0]        out_wr;
  logic [mvsf_pkg::OPTR_W-1:0]        out_rd;
  logic [mvsf_pkg::OCNT_W-1:0]        out_count;
  logic                               out_push;
  logic                               out_pop;

  // Issue only outside the clearing sweep and when the result queue has room for everything in flight.
  assign in_flight  = out_count + mvsf_pkg::OCNT_W'(s1_valid);
  assign issue      = work_valid && !clearing &&
                      (in_flight < mvsf_pkg::OCNT_W'(mvsf_pkg::OUT_DEPTH));
  assign work_ready = issue;
  assign busy       = clearing;

  always_comb begin
    cur_mask  = byp_hit ? byp_mask : mask_rd;
    prev_cut  = mvsf_pkg::cut_to_width(cfg.element_width, byp_hit ? byp_prev : prev_rd);
    live_next = s1.first_of_pass ? (count != '0) : pass_live;
    base      = (s1.first_of_pass && (count != '0)) ? '0 : count;

    unique case (cfg.scan_mode)
      mvsf_pkg::MODE_ANY: ok = 1'b1;
      mvsf_pkg::MODE_EQ:  ok = cur_mask && s1.eq_hit;
      mvsf_pkg::MODE_INC: ok = cur_mask && (s1.now_value > prev_cut);
      mvsf_pkg::MODE_DEC: ok = cur_mask && (s1.now_value < prev_cut);
      default:            ok = 1'b0;
    endcase

    bit_next   = live_next ? ok : cur_mask;
    count_next = base;
    if (live_next && ok && (base < mvsf_pkg::COUNT_W'(mvsf_pkg::SLOT_COUNT))) begin
      count_next = base + mvsf_pkg::COUNT_W'(1);
    end
    we = s1_valid && live_next;

    result.still_candidate   = bit_next;
    result.candidates_so_far = count_next;
    result.pass_skipped      = !live_next;
  end

  // Slot memory read and write ports.
  always_ff @(posedge clk) begin
    if (issue) begin
      mask_rd <= mask_mem[work.slot_index];
      prev_rd <= prev_mem[work.slot_index];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mask_mem[clear_idx] <= 1'b1;
    end else if (we) begin
      mask_mem[s1.slot_index] <= bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      prev_mem[s1.slot_index] <= s1.sample;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
      s1_valid  <= 1'b0;
      byp_hit   <= 1'b0;
      pass_live <= 1'b0;
      count     <= mvsf_pkg::COUNT_W'(mvsf_pkg::SLOT_COUNT);
    end else begin
      if (clearing) begin
        clear_idx <= clear_idx + mvsf_pkg::SLOT_W'(1);
        if (clear_idx == '1) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= issue;
      byp_hit  <= issue && we && (work.slot_index == s1.slot_index);
      if (s1_valid) begin
        pass_live <= live_next;
        count     <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1       <= work;
      byp_mask <= bit_next;
      byp_prev <= s1.sample;
    end
  end

  // Result queue.
  assign out_push    = s1_valid;
  assign empty       = (out_count == '0);
  assign out_pop     = pop && !empty;
  assign scan_result = out_mem[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wr <= out_wr + mvsf_pkg::OPTR_W'(1);
      end
      if (out_pop) begin
        out_rd <= out_rd + mvsf_pkg::OPTR_W'(1);
      end
      if (out_push && !out_pop) begin
        out_count <= out_count + mvsf_pkg::OCNT_W'(1);
      end else if (out_pop && !out_push) begin
        out_count <= out_count - mvsf_pkg::OCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_mem[out_wr] <= result;
    end
  end

endmodule

// File: rtl/core/mvsf_checker.sv
// Port-level checker of the scan filter unit and its bind to the top level.
`include "memory_value_scan_filter_unit_assert.svh"

module mvsf_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  mvsf_pkg::scan_item_t            scan_item,
  input  logic                            empty,
  input  logic                            pop,
  input  mvsf_pkg::scan_result_t          scan_result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mvsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvsf_pkg::DATA_W-1:0]     cfg_data
);

  mvsf_pkg::scan_mode_t mode_seen;
  logic                 result_taken;
  logic                 item_taken;
  logic [mvsf_pkg::SLOT_W-1:0] slot_seen;

  assign result_taken = pop && !empty;
  assign item_taken   = push && !full;
  assign slot_seen    = scan_item.slot_index;

  // Track the scan mode as written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= mvsf_pkg::MODE_ANY;
    end else if (cfg_valid && cfg_ready && (cfg_index == mvsf_pkg::CFG_SCAN_MODE)) begin
      mode_seen <= mvsf_pkg::scan_mode_t'(cfg_data[1:0]);
    end
  end

  // In unconditional mode every slot of a live pass stays a candidate.
  `MVSF_ASSERT_NOW(a_any_keeps, clk, rst, result_taken && (mode_seen == mvsf_pkg::MODE_ANY) && !scan_result.pass_skipped, scan_result.still_candidate)

  // A skipped pass reports either an empty set or the untouched full set.
  `MVSF_ASSERT_NOW(a_skip_count, clk, rst, result_taken && scan_result.pass_skipped, (scan_result.candidates_so_far == '0) || (scan_result.candidates_so_far == mvsf_pkg::COUNT_W'(mvsf_pkg::SLOT_COUNT)))

  // The count never exceeds the number of slots.
  `MVSF_ASSERT_NOW(a_count_max, clk, rst, !empty || item_taken, scan_result.candidates_so_far <= mvsf_pkg::COUNT_W'(mvsf_pkg::SLOT_COUNT) || empty)

  // A waiting result holds until it is taken.
  `MVSF_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(scan_result))

  // An item offered while full keeps its slot unless push is withdrawn.
  `MVSF_ASSERT_NEXT(a_item_hold, clk, rst, push && full && !$isunknown(slot_seen), $stable(slot_seen) || !push)

endmodule

bind memory_value_scan_filter_unit mvsf_checker u_checker (.*);
